FILE: rtl/dnc_pkg.sv
package dnc_pkg;

	// Default build sizes
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_SPAN   = 8;
	localparam int DEF_PIXEL_BITS = 16;

	// Fixed field widths
	localparam int PIXEL_PORT_W = 16;
	localparam int CONTRAST_W   = 19;
	localparam int ROW_W        = 16;
	localparam int CFG_WID_W    = 12;
	localparam int CFG_HGT_W    = 16;
	localparam int CFG_SPAN_W   = 4;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 2;

	// Register reset values
	localparam int RST_WIDTH     = 2048;
	localparam int RST_HEIGHT    = 1024;
	localparam int RST_SPAN      = 1;
	localparam int RST_BYTE_MODE = 0;

	// Neighbors compared against the center, and the byte mode ceiling (255.0 in half units)
	localparam int NEIGH    = 8;
	localparam int BYTE_SAT = 510;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH     = 2'd0,
		REG_HEIGHT    = 2'd1,
		REG_SPAN      = 2'd2,
		REG_BYTE_MODE = 2'd3
	} cfg_reg_t;

	// Per-item control that travels down the pipeline
	typedef struct packed {
		logic             is_pixel;
		logic             emit;
		logic             interior;
		logic             done;
		logic [ROW_W-1:0] row;
	} meta_t;

endpackage

FILE: rtl/dnc_ctrl.sv
module dnc_ctrl import dnc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_SPAN  = DEF_MAX_SPAN,
	localparam int COL_W    = $clog2(MAX_WIDTH),
	localparam int SPAN_W   = $clog2(MAX_SPAN + 1),
	localparam int ADDR_W   = $clog2(2 * MAX_SPAN * MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic                  op,
	output logic                  enter,
	output logic                  store,
	output logic [ADDR_W-1:0]     addr_new,
	output logic [ADDR_W-1:0]     addr_mid,
	output meta_t                 meta,
	output logic [COL_W-1:0]      col,
	output logic [SPAN_W-1:0]     span_eff,
	output logic                  byte_mode
);

	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int WCMP_W = (WID_W > CFG_WID_W) ? WID_W + 1 : CFG_WID_W + 1;
	localparam int SCMP_W = (SPAN_W > CFG_SPAN_W) ? SPAN_W + 1 : CFG_SPAN_W + 1;
	localparam int SLOT_W = (2 * MAX_SPAN > 1) ? $clog2(2 * MAX_SPAN) : 1;
	localparam int SW2    = SPAN_W + 1;
	localparam int SW3    = SPAN_W + 2;
	localparam int CNT_W  = $clog2(MAX_SPAN * MAX_WIDTH + MAX_SPAN + 1);
	localparam int RX_W   = ROW_W + 1;
	localparam int CX_W   = ((WID_W > SPAN_W) ? WID_W : SPAN_W) + 1;

	logic [CFG_WID_W-1:0]  width_q;
	logic [CFG_HGT_W-1:0]  height_q;
	logic [CFG_SPAN_W-1:0] span_q;
	logic                  byte_q;

	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [WID_W-1:0]     w_eff;
	logic [CFG_HGT_W-1:0] h_eff;
	logic [SPAN_W-1:0]    s_eff;
	logic [CNT_W-1:0]     thr;
	logic                 is_flush;
	logic                 frame_in;
	logic                 primed;
	logic                 emit;
	logic                 in_col_last;
	logic [SW2-1:0]       two_s;
	logic [SW2-1:0]       slot_inc;
	logic [SLOT_W-1:0]    slot_nxt;
	logic [SW3-1:0]       mid_sum;
	logic [SLOT_W-1:0]    slot_mid;
	logic [RX_W-1:0]      r_x;
	logic [RX_W-1:0]      s_r;
	logic [RX_W-1:0]      h_r;
	logic [CX_W-1:0]      c_x;
	logic [CX_W-1:0]      s_c;
	logic [CX_W-1:0]      w_c;
	logic                 out_col_last;
	logic                 done;

	// Clamp the registers to their usable ranges
	always_comb begin
		if (width_q == '0) begin
			w_eff = WID_W'(1);
		end else if (WCMP_W'(width_q) > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(width_q);
		end
		h_eff = (height_q == '0) ? CFG_HGT_W'(1) : height_q;
		if (span_q == '0) begin
			s_eff = SPAN_W'(1);
		end else if (SCMP_W'(span_q) > SCMP_W'(MAX_SPAN)) begin
			s_eff = SPAN_W'(MAX_SPAN);
		end else begin
			s_eff = SPAN_W'(span_q);
		end
	end

	assign span_eff  = s_eff;
	assign byte_mode = byte_q;

	// Classify the item: store a pixel, emit a result, both, or drop it
	assign thr      = CNT_W'(s_eff) * CNT_W'(w_eff) + CNT_W'(s_eff);
	assign is_flush = (op == OP_FLUSH);
	assign frame_in = (in_row_q < h_eff);
	assign primed   = (cnt_q >= thr);
	assign store    = accept && !is_flush && frame_in;
	assign emit     = accept && (is_flush ? !frame_in : (frame_in && primed));
	assign enter    = store || emit;

	// Line store slots: newest row reuses the slot of the row 2*span back
	assign in_col_last = (WID_W'(in_col_q) + WID_W'(1)) >= w_eff;
	assign two_s       = {s_eff, 1'b0};
	assign slot_inc    = SW2'(slot_q) + SW2'(1);
	assign slot_nxt    = (slot_inc >= two_s) ? '0 : SLOT_W'(slot_inc);
	assign mid_sum     = SW3'(slot_q) + SW3'(s_eff);
	assign slot_mid    = (mid_sum >= SW3'(two_s)) ? SLOT_W'(mid_sum - SW3'(two_s))
		: SLOT_W'(mid_sum);
	assign addr_new    = ADDR_W'(slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_q);
	assign addr_mid    = ADDR_W'(slot_mid) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_q);

	// Output position: border test and end of frame
	assign r_x          = RX_W'(out_row_q);
	assign s_r          = RX_W'(s_eff);
	assign h_r          = RX_W'(h_eff);
	assign c_x          = CX_W'(out_col_q);
	assign s_c          = CX_W'(s_eff);
	assign w_c          = CX_W'(w_eff);
	assign out_col_last = (c_x + CX_W'(1)) >= w_c;
	assign done         = ((r_x + RX_W'(1)) >= h_r) && out_col_last;

	always_comb begin
		meta.is_pixel = !is_flush;
		meta.emit     = emit;
		meta.interior = !is_flush && (r_x >= s_r) && ((r_x + s_r) < h_r)
			&& (c_x >= s_c) && ((c_x + s_c) < w_c);
		meta.done     = done;
		meta.row      = out_row_q;
	end

	assign col = out_col_q;

	// Registers and frame counters; any register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= CFG_WID_W'(RST_WIDTH);
			height_q  <= CFG_HGT_W'(RST_HEIGHT);
			span_q    <= CFG_SPAN_W'(RST_SPAN);
			byte_q    <= 1'(RST_BYTE_MODE);
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			slot_q    <= '0;
			cnt_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH: begin
					width_q <= cfg_data[CFG_WID_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= cfg_data[CFG_HGT_W-1:0];
				end
				REG_SPAN: begin
					span_q <= cfg_data[CFG_SPAN_W-1:0];
				end
				REG_BYTE_MODE: begin
					byte_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			slot_q    <= '0;
			cnt_q     <= '0;
		end else begin
			// Advance the input raster position
			if (store) begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
					slot_q   <= slot_nxt;
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (!primed) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			// Advance the output raster position, restart after the last one
			if (emit) begin
				if (done) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					slot_q    <= '0;
					cnt_q     <= '0;
				end else if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

FILE: rtl/dnc_line_mem.sv
module dnc_line_mem import dnc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_SPAN   = DEF_MAX_SPAN,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int DEPTH     = 2 * MAX_SPAN * MAX_WIDTH,
	localparam int ADDR_W    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ADDR_W-1:0]     addr_new,
	input  logic [ADDR_W-1:0]     addr_mid,
	input  logic [PIXEL_BITS-1:0] wdata,
	output logic [PIXEL_BITS-1:0] rd_top,
	output logic [PIXEL_BITS-1:0] rd_mid
);

	logic [PIXEL_BITS-1:0] mem_q [DEPTH];

	// Read the two older rows and replace the oldest with the new pixel
	always_ff @(posedge clk) begin
		if (en) begin
			rd_top          <= mem_q[addr_new];
			rd_mid          <= mem_q[addr_mid];
			mem_q[addr_new] <= wdata;
		end
	end

endmodule

FILE: rtl/dnc_window.sv
module dnc_window import dnc_pkg::*; #(
	parameter int MAX_SPAN   = DEF_MAX_SPAN,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int SPAN_W    = $clog2(MAX_SPAN + 1)
) (
	input  logic                  clk,
	input  logic                  shift_en,
	input  logic [PIXEL_BITS-1:0] row_top,
	input  logic [PIXEL_BITS-1:0] row_mid,
	input  logic [PIXEL_BITS-1:0] row_bot,
	input  logic [SPAN_W-1:0]     span,
	input  logic                  load_en,
	input  logic                  interior,
	output logic [PIXEL_BITS-1:0] diff_s3 [NEIGH]
);

	localparam int TAPS  = 2 * MAX_SPAN + 1;
	localparam int TAP_W = $clog2(TAPS);

	logic [TAPS-1:0][PIXEL_BITS-1:0] top_q;
	logic [TAPS-1:0][PIXEL_BITS-1:0] mid_q;
	logic [TAPS-1:0][PIXEL_BITS-1:0] bot_q;

	logic [TAP_W-1:0]      s_idx;
	logic [TAP_W-1:0]      e_idx;
	logic [PIXEL_BITS-1:0] ctr;
	logic [PIXEL_BITS-1:0] nb [NEIGH];

	function automatic logic [PIXEL_BITS-1:0] absdiff(
		input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b
	);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Shift one pixel into each of the three row lines
	always_ff @(posedge clk) begin
		if (shift_en) begin
			top_q <= {top_q[TAPS-2:0], row_top};
			mid_q <= {mid_q[TAPS-2:0], row_mid};
			bot_q <= {bot_q[TAPS-2:0], row_bot};
		end
	end

	// Pick the center and its eight neighbors at distance span
	assign s_idx = TAP_W'(span);
	assign e_idx = TAP_W'({span, 1'b0});
	assign ctr   = mid_q[s_idx];
	assign nb[0] = top_q[0];
	assign nb[1] = top_q[s_idx];
	assign nb[2] = top_q[e_idx];
	assign nb[3] = mid_q[0];
	assign nb[4] = mid_q[e_idx];
	assign nb[5] = bot_q[0];
	assign nb[6] = bot_q[s_idx];
	assign nb[7] = bot_q[e_idx];

	// Register the absolute differences; border positions give zero
	for (genvar g = 0; g < NEIGH; g++) begin : g_diff
		always_ff @(posedge clk) begin
			if (load_en) begin
				diff_s3[g] <= interior ? absdiff(nb[g], ctr) : '0;
			end
		end
	end

endmodule

FILE: rtl/dnc_out.sv
module dnc_out import dnc_pkg::*; #(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int COL_W      = $clog2(DEF_MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [PIXEL_BITS-1:0] diff [NEIGH],
	input  meta_t                 meta,
	input  logic [COL_W-1:0]      col,
	input  logic                  byte_mode,
	input  logic                  out_ready,
	output logic                  free,
	output logic                  out_valid,
	output logic [CONTRAST_W-1:0] contrast,
	output logic [ROW_W-1:0]      out_row,
	output logic [COL_W-1:0]      out_col,
	output logic                  frame_done
);

	localparam int SUM_W = PIXEL_BITS + 3;

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] sat;

	// Add the eight differences and clamp in byte mode
	always_comb begin
		sum = SUM_W'(diff[0]) + SUM_W'(diff[1]) + SUM_W'(diff[2]) + SUM_W'(diff[3])
			+ SUM_W'(diff[4]) + SUM_W'(diff[5]) + SUM_W'(diff[6]) + SUM_W'(diff[7]);
		sat = (byte_mode && (sum > SUM_W'(BYTE_SAT))) ? SUM_W'(BYTE_SAT) : sum;
	end

	assign free = !out_valid || out_ready;

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			contrast   <= CONTRAST_W'(sat);
			out_row    <= meta.row;
			out_col    <= col;
			frame_done <= meta.done;
		end
	end

endmodule

FILE: rtl/dilated_neighbor_contrast_filter_core.sv
// Channel | Handshake            | Payload
// config  | cfg_we               | cfg_index, cfg_data
// input   | in_valid / in_ready  | op, pixel
// output  | out_valid / out_ready| contrast, out_row, out_col, frame_done
//
// One item per clock while in_ready is high: the line store reads two rows
// and writes one in the same cycle, so pixels stream without a gap. A result
// passes the line store read, window, differences and sum stages in order.
// Reset clears the counters, valid bits and registers (to their defaults);
// the line store and window hold unknown data until pixels are written.
// With out_ready low the three inner stages still fill before in_ready drops.
module dilated_neighbor_contrast_filter_core import dnc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_SPAN   = DEF_MAX_SPAN,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic [PIXEL_PORT_W-1:0] pixel,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CONTRAST_W-1:0]   contrast,
	output logic [ROW_W-1:0]        out_row,
	output logic [COL_W-1:0]        out_col,
	output logic                    frame_done
);

	localparam int SPAN_W = $clog2(MAX_SPAN + 1);
	localparam int ADDR_W = $clog2(2 * MAX_SPAN * MAX_WIDTH);

	logic                  accept;
	logic                  enter;
	logic                  store;
	logic [ADDR_W-1:0]     addr_new;
	logic [ADDR_W-1:0]     addr_mid;
	meta_t                 meta;
	logic [COL_W-1:0]      col;
	logic [SPAN_W-1:0]     span_eff;
	logic                  byte_mode;
	logic [PIXEL_BITS-1:0] rd_top_s1;
	logic [PIXEL_BITS-1:0] rd_mid_s1;
	logic [PIXEL_BITS-1:0] diff_s3 [NEIGH];

	logic                  v_s1;
	meta_t                 meta_s1;
	logic [COL_W-1:0]      col_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic                  v_s2;
	meta_t                 meta_s2;
	logic [COL_W-1:0]      col_s2;
	logic                  v_s3;
	meta_t                 meta_s3;
	logic [COL_W-1:0]      col_s3;

	logic out_free;
	logic free3;
	logic s2_go;
	logic free2;
	logic s1_go;
	logic free1;
	logic load3;

	// Stage flow: an item leaves when the next stage is empty or moving on, or emits nothing
	assign free3    = !v_s3 || out_free;
	assign s2_go    = v_s2 && (free3 || !meta_s2.emit);
	assign free2    = !v_s2 || s2_go;
	assign s1_go    = v_s1 && free2;
	assign free1    = !v_s1 || s1_go;
	assign load3    = free3 && s2_go && meta_s2.emit;
	assign in_ready = free1;
	assign accept   = in_valid && in_ready;

	dnc_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_SPAN  (MAX_SPAN)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.op        (op),
		.enter     (enter),
		.store     (store),
		.addr_new  (addr_new),
		.addr_mid  (addr_mid),
		.meta      (meta),
		.col       (col),
		.span_eff  (span_eff),
		.byte_mode (byte_mode)
	);

	dnc_line_mem #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_SPAN   (MAX_SPAN),
		.PIXEL_BITS (PIXEL_BITS)
	) u_line_mem (
		.clk      (clk),
		.en       (store),
		.addr_new (addr_new),
		.addr_mid (addr_mid),
		.wdata    (pixel[PIXEL_BITS-1:0]),
		.rd_top   (rd_top_s1),
		.rd_mid   (rd_mid_s1)
	);

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (free1) begin
				v_s1 <= enter;
			end
			if (free2) begin
				v_s2 <= s1_go;
			end
			if (free3) begin
				v_s3 <= s2_go && meta_s2.emit;
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (enter) begin
			meta_s1 <= meta;
			col_s1  <= col;
			pix_s1  <= pixel[PIXEL_BITS-1:0];
		end
		if (s1_go) begin
			meta_s2 <= meta_s1;
			col_s2  <= col_s1;
		end
		if (load3) begin
			meta_s3 <= meta_s2;
			col_s3  <= col_s2;
		end
	end

	dnc_window #(
		.MAX_SPAN   (MAX_SPAN),
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk      (clk),
		.shift_en (s1_go && meta_s1.is_pixel),
		.row_top  (rd_top_s1),
		.row_mid  (rd_mid_s1),
		.row_bot  (pix_s1),
		.span     (span_eff),
		.load_en  (load3),
		.interior (meta_s2.interior),
		.diff_s3  (diff_s3)
	);

	dnc_out #(
		.PIXEL_BITS (PIXEL_BITS),
		.COL_W      (COL_W)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (v_s3),
		.diff       (diff_s3),
		.meta       (meta_s3),
		.col        (col_s3),
		.byte_mode  (byte_mode),
		.out_ready  (out_ready),
		.free       (out_free),
		.out_valid  (out_valid),
		.contrast   (contrast),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_done (frame_done)
	);

endmodule

FILE: rtl/dnc_checker.sv
module dnc_checker import dnc_pkg::*; #(
	parameter int COL_W = $clog2(DEF_MAX_WIDTH)
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [CONTRAST_W-1:0] contrast,
	input logic [ROW_W-1:0]      out_row,
	input logic [COL_W-1:0]      out_col,
	input logic                  frame_done
);

	logic             bm_q;
	logic             seen_q;
	logic             last_done_q;
	logic [ROW_W-1:0] last_row_q;
	logic [COL_W-1:0] last_col_q;

	// Track byte mode and the position of the last result taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bm_q        <= 1'(RST_BYTE_MODE);
			seen_q      <= 1'b0;
			last_done_q <= 1'b0;
			last_row_q  <= '0;
			last_col_q  <= '0;
		end else if (cfg_we) begin
			seen_q <= 1'b0;
			if (cfg_index == REG_BYTE_MODE) begin
				bm_q <= cfg_data[0];
			end
		end else if (out_valid && out_ready) begin
			seen_q      <= 1'b1;
			last_done_q <= frame_done;
			last_row_q  <= out_row;
			last_col_q  <= out_col;
		end
	end

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(contrast) && $stable(out_row)
			&& $stable(out_col) && $stable(frame_done))
		else $error("stalled result changed");

	// Results follow raster order and restart after the end of frame
	a_raster: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> (last_done_q ? (out_row == '0 && out_col == '0)
			: ((out_row == last_row_q && out_col == last_col_q + COL_W'(1))
			|| (out_col == '0 && out_row == last_row_q + ROW_W'(1)))))
		else $error("result position out of raster order");

	// First row and first column are always border
	a_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_row == '0 || out_col == '0) |-> contrast == '0)
		else $error("border result not zero");

	// Byte mode caps the contrast
	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bm_q |-> contrast <= CONTRAST_W'(BYTE_SAT))
		else $error("byte mode contrast above ceiling");

endmodule

bind dilated_neighbor_contrast_filter_core dnc_checker #(
	.COL_W ($bits(out_col))
) u_dnc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index),
	.cfg_data   (cfg_data),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.contrast   (contrast),
	.out_row    (out_row),
	.out_col    (out_col),
	.frame_done (frame_done)
);
